[sv/bth_pkg.sv]
// shared constants, payload types and access types of the boundary tag heap allocator
package bth_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int TAG_OVERHEAD = 24;
	localparam int NEXT_OFF     = 4;
	localparam int PREV_OFF     = 4 + (TAG_OVERHEAD - 8) / 2;
	localparam int STORE_WORDS  = (HEAP_BYTES + 3) / 4;
	localparam int ADDR_W       = $clog2(HEAP_BYTES);
	localparam int WADDR_W      = $clog2(STORE_WORDS);
	localparam int MAX_WALK     = HEAP_BYTES / TAG_OVERHEAD + 1;
	localparam int WALK_W       = $clog2(MAX_WALK + 1);
	localparam logic [31:0] NIL = 32'hFFFF_FFFF;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_INIT  = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_NOFIT = 2'd1;
	localparam logic [1:0] STS_BAD   = 2'd2;
	localparam logic [1:0] STS_IGN   = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] request_size;
		logic [15:0] handle;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] handle_out;
		logic [1:0]  status;
	} rsp_t;

	// one 32-bit tag access at any byte address
	typedef struct packed {
		logic              go;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
	} acc_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] rdata;
	} acc_rsp_t;

endpackage

[sv/bth_ram.sv]
// generic single port ram with registered read
module bth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[sv/bth_word_port.sv]
// unaligned 32-bit tag read and write over two storage words
module bth_word_port (
	input  logic              clk,
	input  logic              arst_n,
	input  bth_pkg::acc_req_t req,
	output bth_pkg::acc_rsp_t rsp
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_R1   = 2'd1;
	localparam logic [1:0] P_R2   = 2'd2;
	localparam logic [1:0] P_W1   = 2'd3;

	logic [1:0]                  pst_q;
	logic                        we_q;
	logic [bth_pkg::WADDR_W-1:0] w0_q;
	logic [1:0]                  off_q;
	logic [31:0]                 wd_q, d0_q, hi_q;

	logic                        ram_en, ram_we;
	logic [bth_pkg::WADDR_W-1:0] ram_addr;
	logic [31:0]                 ram_wd, ram_rd;
	logic [5:0]                  sh;
	logic [63:0]                 comb, mask, ins, merged, shifted;

	bth_ram #(.WIDTH(32), .DEPTH(bth_pkg::STORE_WORDS)) u_ram (
		.clk(clk), .en(ram_en), .we(ram_we), .addr(ram_addr),
		.wdata(ram_wd), .rdata(ram_rd)
	);

	assign sh      = {off_q, 3'b000};
	assign comb    = {ram_rd, d0_q};
	assign mask    = {32'd0, 32'hFFFF_FFFF} << sh;
	assign ins     = {32'd0, wd_q} << sh;
	assign merged  = (comb & ~mask) | ins;
	assign shifted = comb >> sh;

	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = w0_q;
		ram_wd   = merged[31:0];
		rsp.busy = (pst_q != P_IDLE);
		rsp.done = 1'b0;
		rsp.rdata = shifted[31:0];
		unique case (pst_q)
			P_IDLE: begin
				ram_en   = req.go;
				ram_addr = req.addr[bth_pkg::ADDR_W-1:2];
			end
			P_R1: begin
				ram_en   = 1'b1;
				ram_addr = w0_q + 1'b1;
			end
			P_R2: begin
				ram_en   = we_q;
				ram_we   = we_q;
				rsp.done = !we_q;
			end
			P_W1: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = w0_q + 1'b1;
				ram_wd   = hi_q;
				rsp.done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q <= P_IDLE;
			we_q  <= 1'b0;
			w0_q  <= '0;
			off_q <= '0;
			wd_q  <= '0;
			d0_q  <= '0;
			hi_q  <= '0;
		end else begin
			unique case (pst_q)
				P_IDLE: begin
					if (req.go) begin
						we_q  <= req.we;
						w0_q  <= req.addr[bth_pkg::ADDR_W-1:2];
						off_q <= req.addr[1:0];
						wd_q  <= req.wdata;
						pst_q <= P_R1;
					end
				end
				P_R1: begin
					d0_q  <= ram_rd;
					pst_q <= P_R2;
				end
				P_R2: begin
					hi_q  <= merged[63:32];
					pst_q <= we_q ? P_W1 : P_IDLE;
				end
				P_W1: pst_q <= P_IDLE;
				default: pst_q <= P_IDLE;
			endcase
		end
	end

endmodule

[sv/boundary_tag_heap_allocator.sv]
// top level: request sequencer of the boundary tag first fit heap allocator
//
// usage
// - request channel: req carries action, request_size and handle; an item is
//   taken at a clock edge with req_valid high and req_stall low
// - response channel: rsp carries ok, handle_out and status, held in an
//   output register; rsp_stall from the receiver holds it in place
// - heap_size_we / heap_size_wdata load the heap size used by the next init
// - every tag is a 32-bit word at any byte address, reached through one shared
//   word port: a read fetches two storage words, a write reads both and
//   writes them back (read-modify-write)
// - init writes one free block over the whole heap; a free that passes the
//   handle checks runs the steps of its merge case, alloc reads each free
//   block visited and then splits or unlinks the chosen one
// - one item at a time: req_stall stays high from acceptance until the result
//   has moved into the output register; a new item is taken while that
//   result still waits on a stalled receiver
// - reset empties the free list, marks the heap uninitialised and sets the
//   search to start from the head; heap contents are undefined until an init
module boundary_tag_heap_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          heap_size_we,
	input  logic [16:0]   heap_size_wdata,
	input  logic          req_valid,
	output logic          req_stall,
	input  bth_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bth_pkg::rsp_t rsp
);

	// sequencer states
	localparam logic [6:0] ST_IDLE = 7'd0;
	localparam logic [6:0] ST_DISP = 7'd1;
	localparam logic [6:0] ST_WAIT = 7'd2;
	localparam logic [6:0] ST_DONE = 7'd3;
	localparam logic [6:0] ST_FOK  = 7'd4;
	localparam logic [6:0] ST_ALP  = 7'd5;
	localparam logic [6:0] ST_ACHK = 7'd6;
	localparam logic [6:0] ST_AADV = 7'd7;
	localparam logic [6:0] ST_S1   = 7'd8;
	localparam logic [6:0] ST_S2   = 7'd9;
	localparam logic [6:0] ST_S3   = 7'd10;
	localparam logic [6:0] ST_S4   = 7'd11;
	localparam logic [6:0] ST_S5   = 7'd12;
	localparam logic [6:0] ST_S6   = 7'd13;
	localparam logic [6:0] ST_S7   = 7'd14;
	localparam logic [6:0] ST_S8   = 7'd15;
	localparam logic [6:0] ST_S9   = 7'd16;
	localparam logic [6:0] ST_S10  = 7'd17;
	localparam logic [6:0] ST_S11  = 7'd18;
	localparam logic [6:0] ST_S12  = 7'd19;
	localparam logic [6:0] ST_S13  = 7'd20;
	localparam logic [6:0] ST_S14  = 7'd21;
	localparam logic [6:0] ST_S15  = 7'd22;
	localparam logic [6:0] ST_S16  = 7'd23;
	localparam logic [6:0] ST_U1   = 7'd24;
	localparam logic [6:0] ST_U2   = 7'd25;
	localparam logic [6:0] ST_U3   = 7'd26;
	localparam logic [6:0] ST_U4   = 7'd27;
	localparam logic [6:0] ST_U5   = 7'd28;
	localparam logic [6:0] ST_I1   = 7'd29;
	localparam logic [6:0] ST_I2   = 7'd30;
	localparam logic [6:0] ST_I3   = 7'd31;
	localparam logic [6:0] ST_F1   = 7'd32;
	localparam logic [6:0] ST_F2   = 7'd33;
	localparam logic [6:0] ST_F3   = 7'd34;
	localparam logic [6:0] ST_F4   = 7'd35;
	localparam logic [6:0] ST_F5   = 7'd36;
	localparam logic [6:0] ST_F6   = 7'd37;
	localparam logic [6:0] ST_F7   = 7'd38;
	localparam logic [6:0] ST_F8   = 7'd39;
	localparam logic [6:0] ST_F9   = 7'd40;
	localparam logic [6:0] ST_F10  = 7'd41;
	localparam logic [6:0] ST_FSEL = 7'd42;
	localparam logic [6:0] ST_G1   = 7'd43;
	localparam logic [6:0] ST_G2   = 7'd44;
	localparam logic [6:0] ST_G3   = 7'd45;
	localparam logic [6:0] ST_G4   = 7'd46;
	localparam logic [6:0] ST_G5   = 7'd47;
	localparam logic [6:0] ST_G5A  = 7'd48;
	localparam logic [6:0] ST_G5B  = 7'd49;
	localparam logic [6:0] ST_G6   = 7'd50;
	localparam logic [6:0] ST_G7   = 7'd51;
	localparam logic [6:0] ST_G8   = 7'd52;
	localparam logic [6:0] ST_G9   = 7'd53;
	localparam logic [6:0] ST_G10  = 7'd54;
	localparam logic [6:0] ST_G11  = 7'd55;
	localparam logic [6:0] ST_LF   = 7'd56;
	localparam logic [6:0] ST_LF1  = 7'd57;
	localparam logic [6:0] ST_H1   = 7'd58;
	localparam logic [6:0] ST_H2   = 7'd59;
	localparam logic [6:0] ST_R1   = 7'd60;
	localparam logic [6:0] ST_R2   = 7'd61;
	localparam logic [6:0] ST_R3   = 7'd62;
	localparam logic [6:0] ST_R4   = 7'd63;
	localparam logic [6:0] ST_R5   = 7'd64;
	localparam logic [6:0] ST_R6   = 7'd65;
	localparam logic [6:0] ST_R7   = 7'd66;
	localparam logic [6:0] ST_R8   = 7'd67;
	localparam logic [6:0] ST_R9   = 7'd68;
	localparam logic [6:0] ST_R10  = 7'd69;
	localparam logic [6:0] ST_R11  = 7'd70;
	localparam logic [6:0] ST_R12  = 7'd71;
	localparam logic [6:0] ST_N1   = 7'd72;
	localparam logic [6:0] ST_N2   = 7'd73;

	localparam logic [31:0] NXO = 32'(bth_pkg::NEXT_OFF);
	localparam logic [31:0] PVO = 32'(bth_pkg::PREV_OFF);
	localparam logic [31:0] OVH = 32'(bth_pkg::TAG_OVERHEAD);

	logic [6:0]                 state_q, ret_q;
	bth_pkg::req_t              req_q;
	bth_pkg::rsp_t              res_q, rsp_q;
	logic                       rsp_valid_q;
	logic [16:0]                heap_size_q, active_q, need_q;
	logic [31:0]                head_q, tail_q, cur_q, p_q, n_q, sz_q, tmp_q, rd_q;
	logic [31:0]                left_q, right_q;
	logic [15:0]                blk_q;
	logic                       dir_q, fh_q, lf_q, rf_q;
	logic [bth_pkg::WALK_W-1:0] walk_q;

	// tag access request registers
	logic                       acc_go_q, acc_we_q;
	logic [bth_pkg::ADDR_W-1:0] acc_addr_q;
	logic [31:0]                acc_wd_q;
	bth_pkg::acc_req_t          acc_req;
	bth_pkg::acc_rsp_t          acc_rsp;

	// derived values
	logic [31:0] nb, bw, need32;
	logic        fit, split;
	logic signed [33:0] rsum;

	assign bw     = {16'd0, blk_q};
	assign need32 = {15'd0, need_q};
	assign nb     = cur_q + need32;
	assign fit    = $signed(rd_q) >= $signed(need32);
	assign split  = $signed(rd_q) > $signed(need32 + OVH);
	assign rsum   = $signed({18'd0, blk_q}) + $signed({{2{sz_q[31]}}, sz_q});

	assign acc_req.go    = acc_go_q;
	assign acc_req.we    = acc_we_q;
	assign acc_req.addr  = acc_addr_q;
	assign acc_req.wdata = acc_wd_q;

	bth_word_port u_port (
		.clk(clk), .arst_n(arst_n), .req(acc_req), .rsp(acc_rsp)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic        go, we;
		logic [31:0] g, a, d;
		logic [6:0]  nx;
		logic [16:0] nreq;
		logic [15:0] hb;
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			heap_size_q <= 17'(bth_pkg::HEAP_BYTES);
			active_q    <= '0;
			need_q      <= '0;
			head_q      <= bth_pkg::NIL;
			tail_q      <= bth_pkg::NIL;
			cur_q       <= '0;
			p_q         <= '0;
			n_q         <= '0;
			sz_q        <= '0;
			tmp_q       <= '0;
			rd_q        <= '0;
			left_q      <= '0;
			right_q     <= '0;
			blk_q       <= '0;
			dir_q       <= 1'b1;
			fh_q        <= 1'b0;
			lf_q        <= 1'b0;
			rf_q        <= 1'b0;
			walk_q      <= '0;
			acc_go_q    <= 1'b0;
			acc_we_q    <= 1'b0;
			acc_addr_q  <= '0;
			acc_wd_q    <= '0;
		end else begin
			go   = 1'b0;
			we   = 1'b0;
			g    = 32'd0;
			a    = 32'd0;
			d    = 32'd0;
			nx   = state_q;
			nreq = {1'b0, req_q.request_size} + 17'(bth_pkg::TAG_OVERHEAD);
			hb   = req_q.handle - 16'(bth_pkg::TAG_OVERHEAD - 4);

			if (heap_size_we) begin
				heap_size_q <= heap_size_wdata;
			end
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					res_q.handle_out <= '0;
					res_q.ok         <= 1'b0;
					unique case (req_q.action)
						bth_pkg::ACT_ALLOC: begin
							need_q <= nreq;
							if (active_q == '0 || nreq > active_q) begin
								res_q.status <= bth_pkg::STS_BAD;
								state_q      <= ST_DONE;
							end else if (head_q == bth_pkg::NIL) begin
								res_q.status <= bth_pkg::STS_NOFIT;
								state_q      <= ST_DONE;
							end else begin
								fh_q    <= dir_q;
								dir_q   <= !dir_q;
								cur_q   <= dir_q ? head_q : tail_q;
								walk_q  <= '0;
								state_q <= ST_ALP;
							end
						end
						bth_pkg::ACT_FREE: begin
							if (req_q.handle == '0 || active_q == '0 ||
							    req_q.handle < 16'(bth_pkg::TAG_OVERHEAD - 4) ||
							    {1'b0, hb} >= active_q) begin
								res_q.status <= bth_pkg::STS_IGN;
								state_q      <= ST_DONE;
							end else begin
								blk_q <= hb;
								go = 1'b1; a = {16'd0, hb}; nx = ST_F1;
							end
						end
						bth_pkg::ACT_INIT: begin
							if (heap_size_q > 17'(bth_pkg::TAG_OVERHEAD) &&
							    heap_size_q <= 17'(bth_pkg::HEAP_BYTES)) begin
								active_q <= heap_size_q;
								head_q   <= 32'd0;
								tail_q   <= 32'd0;
								go = 1'b1; we = 1'b1; a = 32'd0;
								d = {15'd0, heap_size_q}; nx = ST_I1;
							end else begin
								res_q.status <= bth_pkg::STS_BAD;
								state_q      <= ST_DONE;
							end
						end
						default: begin
							res_q.status <= bth_pkg::STS_BAD;
							state_q      <= ST_DONE;
						end
					endcase
				end
				ST_WAIT: begin
					if (acc_rsp.done) begin
						if (!acc_we_q) begin
							rd_q <= acc_rsp.rdata;
						end
						state_q <= ret_q;
					end
				end
				ST_FOK: begin
					res_q.ok     <= 1'b1;
					res_q.status <= bth_pkg::STS_OK;
					res_q.handle_out <= (req_q.action == bth_pkg::ACT_ALLOC) ?
						16'(cur_q + OVH - 32'd4) : 16'd0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				// first fit walk
				ST_ALP: begin
					if (cur_q == bth_pkg::NIL ||
					    walk_q >= bth_pkg::WALK_W'(bth_pkg::MAX_WALK)) begin
						res_q.status <= bth_pkg::STS_NOFIT;
						state_q      <= ST_DONE;
					end else begin
						go = 1'b1; a = cur_q; nx = ST_ACHK;
					end
				end
				ST_ACHK: begin
					sz_q <= rd_q;
					if (fit) begin
						go = 1'b1; a = cur_q + PVO;
						nx = split ? ST_S1 : ST_U1;
					end else begin
						walk_q <= walk_q + 1'b1;
						go = 1'b1; a = cur_q + (fh_q ? NXO : PVO); nx = ST_AADV;
					end
				end
				ST_AADV: begin
					cur_q   <= rd_q;
					state_q <= ST_ALP;
				end

				// split: new free block at cur + need takes the list place
				ST_S1:  begin go = 1'b1; we = 1'b1; g = nb; a = nb + PVO; d = rd_q;
					nx = ST_S2; end
				ST_S2:  begin go = 1'b1; a = cur_q + NXO; nx = ST_S3; end
				ST_S3:  begin go = 1'b1; we = 1'b1; g = nb; a = nb + NXO; d = rd_q;
					nx = ST_S4; end
				ST_S4:  begin go = 1'b1; a = cur_q; nx = ST_S5; end
				ST_S5:  begin go = 1'b1; we = 1'b1; a = nb; d = rd_q - need32;
					nx = ST_S6; end
				ST_S6:  begin go = 1'b1; a = nb; nx = ST_S7; end
				ST_S7:  begin go = 1'b1; we = 1'b1; a = nb + rd_q - 32'd4;
					d = 32'd0 - rd_q; nx = ST_S8; end
				ST_S8:  begin go = 1'b1; a = cur_q + PVO; nx = ST_S9; end
				ST_S9:  begin p_q <= rd_q; go = 1'b1; a = cur_q + NXO; nx = ST_S10; end
				ST_S10: begin
					n_q <= rd_q;
					if (p_q == bth_pkg::NIL) begin
						head_q <= nb;
						if (rd_q == bth_pkg::NIL) begin
							tail_q  <= nb;
							state_q <= ST_S12;
						end else begin
							go = 1'b1; we = 1'b1; g = rd_q; a = rd_q + PVO; d = nb;
							nx = ST_S12;
						end
					end else begin
						go = 1'b1; we = 1'b1; g = p_q; a = p_q + NXO; d = nb;
						nx = ST_S11;
					end
				end
				ST_S11: begin
					if (n_q == bth_pkg::NIL) begin
						tail_q  <= nb;
						state_q <= ST_S12;
					end else begin
						go = 1'b1; we = 1'b1; g = n_q; a = n_q + PVO; d = nb;
						nx = ST_S12;
					end
				end
				ST_S12: begin go = 1'b1; we = 1'b1; a = cur_q; d = need32;
					nx = ST_S13; end
				// shared tail: clear links of cur and mark it used
				ST_S13: begin go = 1'b1; we = 1'b1; g = cur_q; a = cur_q + NXO;
					d = bth_pkg::NIL; nx = ST_S14; end
				ST_S14: begin go = 1'b1; we = 1'b1; g = cur_q; a = cur_q + PVO;
					d = bth_pkg::NIL; nx = ST_S15; end
				ST_S15: begin go = 1'b1; a = cur_q; nx = ST_S16; end
				ST_S16: begin go = 1'b1; we = 1'b1; a = cur_q + rd_q - 32'd4; d = rd_q;
					nx = ST_FOK; end

				// unlink the whole block
				ST_U1: begin p_q <= rd_q; go = 1'b1; a = cur_q + NXO; nx = ST_U2; end
				ST_U2: begin
					n_q <= rd_q;
					if (p_q == bth_pkg::NIL) begin
						if (rd_q == bth_pkg::NIL) begin
							head_q  <= bth_pkg::NIL;
							tail_q  <= bth_pkg::NIL;
							state_q <= ST_S13;
						end else begin
							go = 1'b1; g = head_q; a = head_q + NXO; nx = ST_U3;
						end
					end else if (rd_q == bth_pkg::NIL) begin
						go = 1'b1; g = tail_q; a = tail_q + PVO; nx = ST_U4;
					end else begin
						go = 1'b1; we = 1'b1; g = p_q; a = p_q + NXO; d = rd_q;
						nx = ST_U5;
					end
				end
				ST_U3: begin head_q <= rd_q; go = 1'b1; we = 1'b1; g = rd_q;
					a = rd_q + PVO; d = bth_pkg::NIL; nx = ST_S13; end
				ST_U4: begin tail_q <= rd_q; go = 1'b1; we = 1'b1; g = rd_q;
					a = rd_q + NXO; d = bth_pkg::NIL; nx = ST_S13; end
				ST_U5: begin go = 1'b1; we = 1'b1; g = n_q; a = n_q + PVO; d = p_q;
					nx = ST_S13; end

				// init: one free block over the whole heap
				ST_I1: begin go = 1'b1; we = 1'b1; a = NXO; d = bth_pkg::NIL;
					nx = ST_I2; end
				ST_I2: begin go = 1'b1; we = 1'b1; a = PVO; d = bth_pkg::NIL;
					nx = ST_I3; end
				ST_I3: begin go = 1'b1; we = 1'b1; a = {15'd0, active_q} - 32'd4;
					d = 32'd0 - {15'd0, active_q}; nx = ST_FOK; end

				// free: check footer, find neighbours
				ST_F1: begin sz_q <= rd_q; go = 1'b1; a = bw + rd_q - 32'd4;
					nx = ST_F2; end
				ST_F2: begin
					if (rd_q[31]) begin
						res_q.status <= bth_pkg::STS_IGN;
						state_q      <= ST_DONE;
					end else if (blk_q != '0) begin
						go = 1'b1; a = bw - 32'd4; nx = ST_F3;
					end else begin
						left_q  <= bth_pkg::NIL;
						state_q <= ST_F4;
					end
				end
				ST_F3: begin
					left_q  <= bw - (rd_q[31] ? (32'd0 - rd_q) : rd_q);
					state_q <= ST_F4;
				end
				ST_F4: begin
					right_q <= (rsum < $signed({17'd0, active_q})) ? bw + sz_q
						: bth_pkg::NIL;
					go = 1'b1; we = 1'b1; a = bw + sz_q - 32'd4; d = 32'd0 - sz_q;
					nx = ST_F5;
				end
				ST_F5: begin
					if (left_q != bth_pkg::NIL) begin
						go = 1'b1; a = left_q; nx = ST_F6;
					end else begin
						lf_q    <= 1'b0;
						state_q <= ST_F8;
					end
				end
				ST_F6: begin go = 1'b1; a = left_q + rd_q - 32'd4; nx = ST_F7; end
				ST_F7: begin lf_q <= rd_q[31]; state_q <= ST_F8; end
				ST_F8: begin
					if (right_q != bth_pkg::NIL) begin
						go = 1'b1; a = right_q; nx = ST_F9;
					end else begin
						rf_q    <= 1'b0;
						state_q <= ST_FSEL;
					end
				end
				ST_F9:  begin go = 1'b1; a = right_q + rd_q - 32'd4; nx = ST_F10; end
				ST_F10: begin rf_q <= rd_q[31]; state_q <= ST_FSEL; end
				ST_FSEL: begin
					if (lf_q && rf_q) begin
						go = 1'b1; a = right_q + NXO; nx = ST_G1;
					end else if (lf_q) begin
						go = 1'b1; a = left_q; nx = ST_H1;
					end else if (rf_q) begin
						go = 1'b1; a = right_q + PVO; nx = ST_R1;
					end else if (head_q == bth_pkg::NIL) begin
						head_q  <= bw;
						tail_q  <= bw;
						state_q <= ST_FOK;
					end else begin
						go = 1'b1; we = 1'b1; g = tail_q; a = tail_q + NXO; d = bw;
						nx = ST_N1;
					end
				end

				// both neighbours free: drop right from the list, grow left
				ST_G1: begin
					tmp_q <= rd_q;
					if (rd_q == bth_pkg::NIL) begin
						go = 1'b1; g = tail_q; a = tail_q + PVO; nx = ST_G2;
					end else begin
						go = 1'b1; a = right_q + PVO; nx = ST_G3;
					end
				end
				ST_G2: begin tail_q <= rd_q; go = 1'b1; we = 1'b1; g = rd_q;
					a = rd_q + NXO; d = bth_pkg::NIL; nx = ST_G6; end
				ST_G3: begin
					if (rd_q == bth_pkg::NIL) begin
						go = 1'b1; g = head_q; a = head_q + NXO; nx = ST_G4;
					end else begin
						go = 1'b1; we = 1'b1; g = rd_q; a = rd_q + NXO; d = tmp_q;
						nx = ST_G5;
					end
				end
				ST_G4: begin head_q <= rd_q; go = 1'b1; we = 1'b1; g = rd_q;
					a = rd_q + PVO; d = bth_pkg::NIL; nx = ST_G6; end
				ST_G5:  begin go = 1'b1; a = right_q + NXO; nx = ST_G5A; end
				ST_G5A: begin tmp_q <= rd_q; go = 1'b1; a = right_q + PVO;
					nx = ST_G5B; end
				ST_G5B: begin go = 1'b1; we = 1'b1; g = tmp_q; a = tmp_q + PVO;
					d = rd_q; nx = ST_G6; end
				ST_G6: begin go = 1'b1; we = 1'b1; g = right_q; a = right_q + NXO;
					d = bth_pkg::NIL; nx = ST_G7; end
				ST_G7: begin go = 1'b1; we = 1'b1; g = right_q; a = right_q + PVO;
					d = bth_pkg::NIL; nx = ST_G8; end
				ST_G8:  begin go = 1'b1; a = left_q; nx = ST_G9; end
				ST_G9:  begin tmp_q <= rd_q; go = 1'b1; a = right_q; nx = ST_G10; end
				ST_G10: begin tmp_q <= tmp_q + rd_q; go = 1'b1; a = bw; nx = ST_G11; end
				ST_G11: begin go = 1'b1; we = 1'b1; a = left_q; d = tmp_q + rd_q;
					nx = ST_LF; end
				ST_LF:  begin go = 1'b1; a = left_q; nx = ST_LF1; end
				ST_LF1: begin go = 1'b1; we = 1'b1; a = left_q + rd_q - 32'd4;
					d = 32'd0 - rd_q; nx = ST_FOK; end

				// left free only
				ST_H1: begin tmp_q <= rd_q; go = 1'b1; a = bw; nx = ST_H2; end
				ST_H2: begin go = 1'b1; we = 1'b1; a = left_q; d = tmp_q + rd_q;
					nx = ST_LF; end

				// right free only: blk takes the list place of right
				ST_R1: begin p_q <= rd_q; go = 1'b1; a = right_q + NXO; nx = ST_R2; end
				ST_R2: begin n_q <= rd_q; go = 1'b1; we = 1'b1; g = bw; a = bw + PVO;
					d = p_q; nx = ST_R3; end
				ST_R3: begin go = 1'b1; we = 1'b1; g = bw; a = bw + NXO; d = n_q;
					nx = ST_R4; end
				ST_R4: begin
					if (n_q == bth_pkg::NIL) begin
						tail_q <= bw;
						if (p_q == bth_pkg::NIL) begin
							head_q  <= bw;
							state_q <= ST_R6;
						end else begin
							go = 1'b1; we = 1'b1; g = p_q; a = p_q + NXO; d = bw;
							nx = ST_R6;
						end
					end else if (p_q == bth_pkg::NIL) begin
						head_q <= bw;
						go = 1'b1; we = 1'b1; g = n_q; a = n_q + PVO; d = bw;
						nx = ST_R6;
					end else begin
						go = 1'b1; we = 1'b1; g = p_q; a = p_q + NXO; d = bw;
						nx = ST_R5;
					end
				end
				ST_R5: begin go = 1'b1; we = 1'b1; g = n_q; a = n_q + PVO; d = bw;
					nx = ST_R6; end
				ST_R6: begin go = 1'b1; we = 1'b1; g = right_q; a = right_q + NXO;
					d = bth_pkg::NIL; nx = ST_R7; end
				ST_R7: begin go = 1'b1; we = 1'b1; g = right_q; a = right_q + PVO;
					d = bth_pkg::NIL; nx = ST_R8; end
				ST_R8:  begin go = 1'b1; a = bw; nx = ST_R9; end
				ST_R9:  begin tmp_q <= rd_q; go = 1'b1; a = right_q; nx = ST_R10; end
				ST_R10: begin go = 1'b1; we = 1'b1; a = bw; d = tmp_q + rd_q;
					nx = ST_R11; end
				ST_R11: begin go = 1'b1; a = bw; nx = ST_R12; end
				ST_R12: begin go = 1'b1; we = 1'b1; a = bw + rd_q - 32'd4;
					d = 32'd0 - rd_q; nx = ST_FOK; end

				// no merge: append at the tail
				ST_N1: begin go = 1'b1; we = 1'b1; g = bw; a = bw + PVO; d = tail_q;
					nx = ST_N2; end
				ST_N2: begin tail_q <= bw; state_q <= ST_FOK; end

				default: state_q <= ST_IDLE;
			endcase

			// issue a tag access; a link access of the null block is skipped
			acc_go_q <= go && (g != bth_pkg::NIL);
			if (go) begin
				if (g == bth_pkg::NIL) begin
					if (!we) begin
						rd_q <= bth_pkg::NIL;
					end
					state_q <= nx;
				end else begin
					acc_we_q   <= we;
					acc_addr_q <= a[bth_pkg::ADDR_W-1:0];
					acc_wd_q   <= d;
					ret_q      <= nx;
					state_q    <= ST_WAIT;
				end
			end
		end
	end

	// a tag access is only started while the word port is idle
	a_port_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc_go_q |-> !acc_rsp.busy)
		else $error("tag access started while word port busy");

	// the sequencer waits only while an access is in flight
	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && !acc_go_q) |-> acc_rsp.busy)
		else $error("waiting on an idle word port");

	// ok agrees with the status code
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.ok == (rsp.status == bth_pkg::STS_OK)))
		else $error("ok and status disagree");

	// an accepted item blocks the request channel until it finishes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request channel open during an item");

endmodule

[bench/bth_checker.sv]
// result checker for the boundary tag heap allocator: watches both channels and predicts each result
module bth_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          heap_size_we,
	input  logic [16:0]   heap_size_wdata,
	input  logic          req_valid,
	input  logic          req_stall,
	input  bth_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  bth_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);
	import bth_pkg::*;

	logic [7:0]  heap_bytes [HEAP_BYTES];
	logic [31:0] fl_head, fl_tail, live_size;
	logic        walk_fwd;
	logic [16:0] size_reg;
	rsp_t        result_q[$];

	function automatic logic [31:0] rd_word(logic [31:0] a);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < 4; i++)
			v[8*i +: 8] = heap_bytes[(a + i) % HEAP_BYTES];
		return v;
	endfunction

	function automatic void wr_word(logic [31:0] a, logic [31:0] v);
		for (int i = 0; i < 4; i++)
			heap_bytes[(a + i) % HEAP_BYTES] = v[8*i +: 8];
	endfunction

	function automatic longint sgn(logic [31:0] v);
		longint t;
		t = $signed(v);
		return t;
	endfunction

	function automatic logic [31:0] link_nxt(logic [31:0] b);
		return b == NIL ? NIL : rd_word(b + NEXT_OFF);
	endfunction

	function automatic logic [31:0] link_prv(logic [31:0] b);
		return b == NIL ? NIL : rd_word(b + PREV_OFF);
	endfunction

	function automatic void put_nxt(logic [31:0] b, logic [31:0] v);
		if (b != NIL) wr_word(b + NEXT_OFF, v);
	endfunction

	function automatic void put_prv(logic [31:0] b, logic [31:0] v);
		if (b != NIL) wr_word(b + PREV_OFF, v);
	endfunction

	function automatic logic [31:0] footer_of(logic [31:0] b);
		return rd_word(b + rd_word(b) - 4);
	endfunction

	function automatic void put_footer(logic [31:0] b, logic [31:0] v);
		wr_word(b + rd_word(b) - 4, v);
	endfunction

	function automatic void split_blk(logic [31:0] c, logic [31:0] need);
		logic [31:0] nb, p, n;
		nb = c + need;
		put_prv(nb, link_prv(c));
		put_nxt(nb, link_nxt(c));
		wr_word(nb, rd_word(c) - need);
		put_footer(nb, 32'd0 - rd_word(nb));
		p = link_prv(c);
		n = link_nxt(c);
		if (p == NIL) begin
			if (n != NIL) put_prv(n, nb);
			fl_head = nb;
			if (n == NIL) fl_tail = nb;
		end else begin
			put_nxt(p, nb);
			if (n == NIL) fl_tail = nb;
			else put_prv(n, nb);
		end
		wr_word(c, need);
		put_nxt(c, NIL);
		put_prv(c, NIL);
		put_footer(c, rd_word(c));
	endfunction

	function automatic void unlink_blk(logic [31:0] c);
		logic [31:0] p, n;
		p = link_prv(c);
		n = link_nxt(c);
		if (p == NIL) begin
			if (n == NIL) begin
				fl_head = NIL;
				fl_tail = NIL;
			end else begin
				fl_head = link_nxt(fl_head);
				put_prv(fl_head, NIL);
			end
		end else if (n == NIL) begin
			fl_tail = link_prv(fl_tail);
			put_nxt(fl_tail, NIL);
		end else begin
			put_nxt(p, n);
			put_prv(n, p);
		end
		put_nxt(c, NIL);
		put_prv(c, NIL);
		put_footer(c, rd_word(c));
	endfunction

	function automatic logic [1:0] alloc_blk(logic [15:0] req_sz, output logic [15:0] h);
		logic [31:0] cur, need;
		logic        fwd;
		int          walk;
		h = '0;
		need = req_sz + TAG_OVERHEAD;
		fwd = walk_fwd;
		walk = 0;
		if (live_size == 0 || need > live_size) return STS_BAD;
		if (fl_head == NIL) return STS_NOFIT;
		walk_fwd = !fwd;
		cur = fwd ? fl_head : fl_tail;
		while (cur != NIL && walk < MAX_WALK) begin
			if (sgn(rd_word(cur)) >= longint'(need)) break;
			cur = fwd ? link_nxt(cur) : link_prv(cur);
			walk++;
		end
		if (cur == NIL || walk >= MAX_WALK) return STS_NOFIT;
		if (sgn(rd_word(cur)) > longint'(need) + TAG_OVERHEAD) split_blk(cur, need);
		else unlink_blk(cur);
		h = 16'(cur + TAG_OVERHEAD - 4);
		return STS_OK;
	endfunction

	function automatic logic [1:0] free_blk(logic [15:0] hd);
		logic [31:0] blk, sz, left, right, p, n, m;
		logic        lf, rf;
		longint      s;
		left = NIL;
		right = NIL;
		lf = 0;
		rf = 0;
		if (hd == 0 || live_size == 0 || hd < TAG_OVERHEAD - 4) return STS_IGN;
		blk = hd - (TAG_OVERHEAD - 4);
		if (blk >= live_size || sgn(footer_of(blk)) < 0) return STS_IGN;
		sz = rd_word(blk);
		if (blk >= 1) begin
			s = sgn(rd_word(blk - 4));
			m = 32'(s < 0 ? -s : s);
			left = blk - m;
		end
		if (longint'(blk) + sgn(sz) < longint'(live_size)) right = blk + sz;
		put_footer(blk, 32'd0 - sz);
		if (left != NIL && sgn(footer_of(left)) < 0) lf = 1;
		if (right != NIL && sgn(footer_of(right)) < 0) rf = 1;
		if (lf) begin
			if (rf) begin
				// right neighbour leaves the list, all three fold into left
				if (link_nxt(right) == NIL) begin
					fl_tail = link_prv(fl_tail);
					put_nxt(fl_tail, NIL);
				end else if (link_prv(right) == NIL) begin
					fl_head = link_nxt(fl_head);
					put_prv(fl_head, NIL);
				end else begin
					put_nxt(link_prv(right), link_nxt(right));
					put_prv(link_nxt(right), link_prv(right));
				end
				put_nxt(right, NIL);
				put_prv(right, NIL);
				wr_word(left, rd_word(left) + rd_word(right) + rd_word(blk));
			end else
				wr_word(left, rd_word(left) + rd_word(blk));
			put_footer(left, 32'd0 - rd_word(left));
		end else if (rf) begin
			// freed block takes the list place of its right neighbour
			p = link_prv(right);
			n = link_nxt(right);
			put_prv(blk, p);
			put_nxt(blk, n);
			if (n == NIL) begin
				fl_tail = blk;
				if (p == NIL) fl_head = blk;
				else put_nxt(p, blk);
			end else begin
				if (p == NIL) fl_head = blk;
				else put_nxt(p, blk);
				put_prv(n, blk);
			end
			put_nxt(right, NIL);
			put_prv(right, NIL);
			wr_word(blk, rd_word(blk) + rd_word(right));
			put_footer(blk, 32'd0 - rd_word(blk));
		end else if (fl_head == NIL) begin
			fl_head = blk;
			fl_tail = blk;
		end else begin
			put_nxt(fl_tail, blk);
			put_prv(blk, fl_tail);
			fl_tail = blk;
		end
		return STS_OK;
	endfunction

	function automatic rsp_t predict_result(req_t r);
		rsp_t        o;
		logic [15:0] h;
		logic [1:0]  st;
		h = '0;
		st = STS_BAD;
		if (r.action == ACT_ALLOC)
			st = alloc_blk(r.request_size, h);
		else if (r.action == ACT_FREE)
			st = free_blk(r.handle);
		else if (r.action == ACT_INIT) begin
			if (size_reg > TAG_OVERHEAD && size_reg <= HEAP_BYTES) begin
				live_size = size_reg;
				fl_head = 0;
				fl_tail = 0;
				wr_word(0, size_reg);
				put_nxt(0, NIL);
				put_prv(0, NIL);
				put_footer(0, 32'd0 - size_reg);
				st = STS_OK;
			end
		end
		o.ok = st == STS_OK;
		o.handle_out = h;
		o.status = st;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < HEAP_BYTES; i++) heap_bytes[i] = '0;
			fl_head = NIL;
			fl_tail = NIL;
			walk_fwd = 1;
			live_size = 0;
			size_reg = 17'd65536;
			result_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					$error("result with no item outstanding");
					errors++;
				end else begin
					want = result_q.pop_front();
					if (rsp.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, rsp.ok);
						errors++;
					end
					if (rsp.handle_out !== want.handle_out) begin
						$error("handle_out: expected %0d, got %0d", want.handle_out, rsp.handle_out);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
				end
			end
			if (heap_size_we) size_reg = heap_size_wdata;
			if (req_valid && !req_stall) result_q.push_back(predict_result(req));
			pending = result_q.size();
		end
	end

endmodule

[bench/tb.sv]
// testbench top of the boundary tag heap allocator: stimulus, idling and verdict
module tb;
	import bth_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        heap_size_we;
	logic [16:0] heap_size_wdata;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	int          errors;
	int          pending;

	// handles the bench may hand back, and handles already freed in this heap
	logic [15:0] live_q[$];
	logic [15:0] freed_q[$];
	// kind of each item in flight: bit 0 alloc, bits above the heap generation
	int          flight_q[$];
	int          heap_gen;
	int          burst_left;
	int          stall_mode;
	int          stall_cnt;
	int          cur_heap;
	logic        heap_ok;

	boundary_tag_heap_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.heap_size_we    (heap_size_we),
		.heap_size_wdata (heap_size_wdata),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp)
	);

	bth_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.heap_size_we    (heap_size_we),
		.heap_size_wdata (heap_size_wdata),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.errors          (errors),
		.pending         (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#(20 * 80000000);
		$display("Verification failed");
		$finish;
	end

	// receiver: switches among no stall, light random, heavy random and long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
			stall_cnt <= 0;
		end else begin
			if (stall_cnt == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_cnt <= $urandom_range(50, 400);
			end else
				stall_cnt <= stall_cnt - 1;
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 9) < 2);
				2: rsp_stall <= ($urandom_range(0, 9) < 7);
				default: rsp_stall <= (stall_cnt % 40) < 25;
			endcase
		end
	end

	// collect handles from granted allocations of the current heap
	always @(posedge clk) begin
		int kind;
		if (arst_n && rsp_valid && !rsp_stall && flight_q.size() > 0) begin
			kind = flight_q.pop_front();
			if (kind[0] && rsp.ok && (kind >> 1) == heap_gen)
				live_q.push_back(rsp.handle_out);
		end
	end

	// one item; valid stays up across a burst, a gap lowers it after acceptance
	task automatic send_item(logic [1:0] act, logic [15:0] sz, logic [15:0] hd);
		int gap;
		if (act == ACT_INIT) begin
			heap_gen++;
			live_q.delete();
			freed_q.delete();
		end
		req <= '{action: act, request_size: sz, handle: hd};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		flight_q.push_back((heap_gen << 1) | (act == ACT_ALLOC));
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 8);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// waits for every result, then loads the heap size register
	task automatic set_heap(int sz);
		if (req_valid) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		heap_size_we <= 1'b1;
		heap_size_wdata <= 17'(sz);
		@(posedge clk);
		heap_size_we <= 1'b0;
		// a size that init refuses leaves the active heap as it was
		if (sz > TAG_OVERHEAD && sz <= HEAP_BYTES) begin
			cur_heap = sz;
			heap_ok = 1'b1;
		end
	endtask

	task automatic free_live(int idx);
		logic [15:0] h;
		h = live_q[idx];
		live_q.delete(idx);
		freed_q.push_back(h);
		send_item(ACT_FREE, 16'($urandom), h);
	endtask

	task automatic random_item();
		int          pick;
		int          lo;
		int          cap;
		logic [15:0] h;
		pick = $urandom_range(0, 99);
		cap = heap_ok ? ((cur_heap > 800 || cur_heap < 25) ? 200 : cur_heap / 4) : 200;
		if (pick < 40 || (pick < 85 && live_q.size() == 0)) begin
			if ($urandom_range(0, 19) == 0)
				send_item(ACT_ALLOC, 16'($urandom), 16'($urandom));
			else
				send_item(ACT_ALLOC, 16'($urandom_range(0, cap)), 16'($urandom));
		end else if (pick < 85)
			free_live($urandom_range(0, live_q.size() - 1));
		else if (pick < 92 && freed_q.size() > 0) begin
			// double free of a handle from this heap
			send_item(ACT_FREE, 16'($urandom),
				freed_q[$urandom_range(0, freed_q.size() - 1)]);
		end else begin
			// ignored frees: null, below the tag overhead, beyond the heap
			lo = cur_heap + TAG_OVERHEAD;
			case ($urandom_range(0, 2))
				0: h = 16'd0;
				1: h = 16'($urandom_range(1, TAG_OVERHEAD - 5));
				default: h = (heap_ok && cur_heap <= HEAP_BYTES && lo <= 65535)
					? 16'($urandom_range(lo, 65535)) : 16'd0;
			endcase
			send_item(ACT_FREE, 16'($urandom), h);
		end
	endtask

	initial begin
		int sizes[9] = '{65536, 300, 25, 0, 24, 65537, 131071, 2000, 65536};
		logic [15:0] a, b, c;
		arst_n = 1'b0;
		heap_size_we = 1'b0;
		heap_size_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		heap_gen = 0;
		burst_left = 0;
		cur_heap = 65536;
		heap_ok = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before any init: alloc refused, free ignored
		send_item(ACT_ALLOC, 16'd10, 16'd0);
		send_item(ACT_FREE, 16'd0, 16'd100);
		set_heap(65536);
		send_item(ACT_INIT, 16'd0, 16'd0);
		send_item(ACT_ALLOC, 16'd0, 16'hFFFF);
		send_item(ACT_ALLOC, 16'hFFFF, 16'd0);
		send_item(ACT_ALLOC, 16'd65512, 16'd0);
		send_item(ACT_ALLOC, 16'd100, 16'd0);
		send_item(ACT_ALLOC, 16'd100, 16'd0);
		send_item(ACT_ALLOC, 16'd100, 16'd0);
		send_item(ACT_ALLOC, 16'd40, 16'd0);
		set_heap(65536);
		// live handles in order: zero-size block, then three of 100, then 40
		a = live_q[2];
		b = live_q[1];
		c = live_q[3];
		// middle goes to the tail, then merges on the right, then on the left
		live_q.delete(3);
		live_q.delete(2);
		live_q.delete(1);
		freed_q.push_back(a);
		freed_q.push_back(b);
		freed_q.push_back(c);
		send_item(ACT_FREE, 16'd0, a);
		send_item(ACT_FREE, 16'd0, b);
		send_item(ACT_FREE, 16'd0, c);
		send_item(ACT_FREE, 16'd0, 16'd0);
		send_item(ACT_FREE, 16'd0, 16'd19);
		send_item(ACT_FREE, 16'd0, a);
		send_item(ACT_ALLOC, 16'd60, 16'd0);
		send_item(ACT_ALLOC, 16'd60, 16'd0);

		// random phases across heap sizes, failed inits among them
		foreach (sizes[i]) begin
			set_heap(sizes[i]);
			send_item(ACT_INIT, 16'($urandom), 16'($urandom));
			repeat (61) random_item();
		end

		if (req_valid) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
